// ===== design/salc_pkg.sv =====
`default_nettype none

package salc_pkg;

    // Sizing of the tag store.
    localparam int MAX_SETS   = 64;
    localparam int MAX_WAYS   = 8;
    localparam int ADDR_WIDTH = 48;

    localparam int SET_IDX_W    = (MAX_SETS > 1) ? $clog2(MAX_SETS) : 1;
    localparam int MAX_SET_BITS = $clog2(MAX_SETS);
    localparam int WAY_IDX_W    = (MAX_WAYS > 1) ? $clog2(MAX_WAYS) : 1;
    localparam int WAY_CNT_W    = $clog2(MAX_WAYS + 1);
    localparam int RANK_W       = WAY_IDX_W;
    localparam int TAG_W        = ADDR_WIDTH;
    localparam int CNT_W        = 32;

    // Configuration register widths and the register bus.
    localparam int SET_BITS_W   = 3;
    localparam int WAYS_W       = 4;
    localparam int BLOCK_BITS_W = 5;
    localparam int PADDR_W      = 4;
    localparam int PDATA_W      = 32;

    // Register indexes, taken from paddr[3:2].
    localparam logic [1:0] REG_SET_BITS   = 2'd0;
    localparam logic [1:0] REG_WAYS       = 2'd1;
    localparam logic [1:0] REG_BLOCK_BITS = 2'd2;

    // Reset values of the registers.
    localparam logic [SET_BITS_W-1:0]   RST_SET_BITS   = 3'd4;
    localparam logic [WAYS_W-1:0]       RST_WAYS       = 4'd1;
    localparam logic [BLOCK_BITS_W-1:0] RST_BLOCK_BITS = 5'd4;

    typedef enum logic [1:0] {
        CMD_LOAD   = 2'd0,
        CMD_STORE  = 2'd1,
        CMD_MODIFY = 2'd2,
        CMD_IFETCH = 2'd3
    } cmd_t;

    typedef enum logic [1:0] {
        OUT_HIT   = 2'd0,
        OUT_MISS  = 2'd1,
        OUT_EVICT = 2'd2
    } outcome_t;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_LOOKUP,
        ST_REREAD
    } state_t;

    // Input word.
    typedef struct packed {
        logic [1:0]            cmd;
        logic [ADDR_WIDTH-1:0] address;
    } in_word_t;

    // Result word.
    typedef struct packed {
        logic [1:0]       outcome;
        logic             last_of_item;
        logic [CNT_W-1:0] hit_total;
        logic [CNT_W-1:0] miss_total;
        logic [CNT_W-1:0] eviction_total;
    } out_word_t;

    // Effective configuration after clamping.
    typedef struct packed {
        logic [SET_BITS_W-1:0]   set_bits;
        logic [WAY_CNT_W-1:0]    ways;
        logic [BLOCK_BITS_W-1:0] block_bits;
    } cfg_t;

    // One way of a set, and a whole set as stored in one memory row.
    typedef struct packed {
        logic              valid;
        logic [RANK_W-1:0] rank;
        logic [TAG_W-1:0]  tag;
    } way_t;

    typedef way_t [MAX_WAYS-1:0] row_t;

    localparam int ROW_W = $bits(row_t);

    function automatic logic [CNT_W-1:0] sat_inc(input logic [CNT_W-1:0] v);
        sat_inc = (v == {CNT_W{1'b1}}) ? v : v + 1'b1;
    endfunction

endpackage

`default_nettype wire

// ===== design/salc_set_ram.sv =====
`default_nettype none

// Single-port synchronous RAM with a registered read.
module salc_set_ram #(
    parameter int WIDTH  = 8,
    parameter int DEPTH  = 64,
    parameter int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  wire logic              clk,
    input  wire logic              we,
    input  wire logic              re,
    input  wire logic [ADDR_W-1:0] addr,
    input  wire logic [WIDTH-1:0]  wdata,
    output logic      [WIDTH-1:0]  rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[addr] <= wdata;
        end
        if (re)
        begin
            rdata <= mem[addr];
        end
    end

endmodule

`default_nettype wire

// ===== design/salc_cfg.sv =====
`default_nettype none

// Register bank on the APB-style port, with clamping of the raw values.
module salc_cfg (
    input  wire logic                            clk,
    input  wire logic                            rst_n,
    input  wire logic                            psel,
    input  wire logic                            penable,
    input  wire logic                            pwrite,
    input  wire logic [salc_pkg::PADDR_W-1:0]    paddr,
    input  wire logic [salc_pkg::PDATA_W-1:0]    pwdata,
    output logic      [salc_pkg::PDATA_W-1:0]    prdata,
    output logic                                 pready,
    output salc_pkg::cfg_t                       cfg
);
    import salc_pkg::*;

    logic [SET_BITS_W-1:0]   set_bits_reg;
    logic [WAYS_W-1:0]       ways_reg;
    logic [BLOCK_BITS_W-1:0] block_bits_reg;
    logic                    wr_en;
    logic [1:0]              reg_idx;

    assign pready  = 1'b1;
    assign wr_en   = psel && penable && pwrite;
    assign reg_idx = paddr[3:2];

    // Register writes.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            set_bits_reg   <= RST_SET_BITS;
            ways_reg       <= RST_WAYS;
            block_bits_reg <= RST_BLOCK_BITS;
        end
        else if (wr_en)
        begin
            case (reg_idx)
                REG_SET_BITS:   set_bits_reg   <= pwdata[SET_BITS_W-1:0];
                REG_WAYS:       ways_reg       <= pwdata[WAYS_W-1:0];
                REG_BLOCK_BITS: block_bits_reg <= pwdata[BLOCK_BITS_W-1:0];
                default:        ;
            endcase
        end
    end

    // Read back the raw register values.
    always_comb
    begin
        case (reg_idx)
            REG_SET_BITS:   prdata = PDATA_W'(set_bits_reg);
            REG_WAYS:       prdata = PDATA_W'(ways_reg);
            REG_BLOCK_BITS: prdata = PDATA_W'(block_bits_reg);
            default:        prdata = '0;
        endcase
    end

    // Clamp the set count to the memory depth and the ways to one up to the row width.
    always_comb
    begin
        if (int'(set_bits_reg) > MAX_SET_BITS)
        begin
            cfg.set_bits = SET_BITS_W'(MAX_SET_BITS);
        end
        else
        begin
            cfg.set_bits = set_bits_reg;
        end

        if (ways_reg == '0)
        begin
            cfg.ways = WAY_CNT_W'(1);
        end
        else if (int'(ways_reg) > MAX_WAYS)
        begin
            cfg.ways = WAY_CNT_W'(MAX_WAYS);
        end
        else
        begin
            cfg.ways = WAY_CNT_W'(ways_reg);
        end

        cfg.block_bits = block_bits_reg;
    end

endmodule

`default_nettype wire

// ===== design/salc_lookup.sv =====
`default_nettype none

// Tag compare, victim choice and recency update for one set row.
module salc_lookup (
    input  salc_pkg::row_t                    row,
    input  wire logic [salc_pkg::TAG_W-1:0]   tag,
    input  wire logic [salc_pkg::WAY_CNT_W-1:0] ways,
    output salc_pkg::row_t                    new_row,
    output logic [1:0]                        outcome
);
    import salc_pkg::*;

    localparam logic [RANK_W-1:0] RANK_MAX = RANK_W'(MAX_WAYS - 1);

    logic [MAX_WAYS-1:0]  in_use;
    logic                 hit_any;
    logic [WAY_IDX_W-1:0] hit_way;
    logic                 inv_any;
    logic [WAY_IDX_W-1:0] inv_way;
    logic [WAY_IDX_W-1:0] lru_way;
    logic [RANK_W-1:0]    lru_rank;
    logic [WAY_IDX_W-1:0] touch_way;
    logic [RANK_W:0]      old_rank;

    // Searches over the ways that take part: first hit, first empty, oldest.
    always_comb
    begin
        hit_any  = 1'b0;
        hit_way  = '0;
        inv_any  = 1'b0;
        inv_way  = '0;
        lru_way  = '0;
        lru_rank = row[0].rank;
        for (int i = 0; i < MAX_WAYS; i++)
        begin
            in_use[i] = (WAY_CNT_W'(i) < ways);
            if (in_use[i] && row[i].valid && (row[i].tag == tag) && !hit_any)
            begin
                hit_any = 1'b1;
                hit_way = WAY_IDX_W'(i);
            end
            if (in_use[i] && !row[i].valid && !inv_any)
            begin
                inv_any = 1'b1;
                inv_way = WAY_IDX_W'(i);
            end
            if (i > 0 && in_use[i] && (row[i].rank > lru_rank))
            begin
                lru_way  = WAY_IDX_W'(i);
                lru_rank = row[i].rank;
            end
        end
    end

    // Pick the way to touch and the rank it had before.
    always_comb
    begin
        if (hit_any)
        begin
            outcome   = OUT_HIT;
            touch_way = hit_way;
            old_rank  = {1'b0, row[hit_way].rank};
        end
        else if (inv_any)
        begin
            // A newly filled line counts as older than all others.
            outcome   = OUT_MISS;
            touch_way = inv_way;
            old_rank  = (RANK_W + 1)'(MAX_WAYS);
        end
        else
        begin
            outcome   = OUT_EVICT;
            touch_way = lru_way;
            old_rank  = {1'b0, lru_rank};
        end
    end

    // Age the younger valid lines and make the touched line most recent.
    always_comb
    begin
        for (int i = 0; i < MAX_WAYS; i++)
        begin
            new_row[i] = row[i];
            if (in_use[i] && (WAY_IDX_W'(i) != touch_way) && row[i].valid &&
                ({1'b0, row[i].rank} < old_rank) && (row[i].rank != RANK_MAX))
            begin
                new_row[i].rank = row[i].rank + 1'b1;
            end
        end
        new_row[touch_way].valid = 1'b1;
        new_row[touch_way].rank  = '0;
        new_row[touch_way].tag   = tag;
    end

endmodule

`default_nettype wire

// ===== design/set_associative_lru_cache_sim.sv =====
`default_nettype none

// Set-associative cache tag store with least-recently-used replacement. Each
// input word is a trace access (load, store, modify or instruction fetch) and
// a byte address; each cache access returns one result word with the outcome
// and saturating hit, miss and eviction totals, and last_of_item marks the
// final result of an input word. Each set lives in one row of a single-port
// memory, so an access first reads the row, then compares, updates and
// writes it back. A load or store makes one access and a modify two (the
// second access rereads the row just written); an instruction fetch is
// taken and gives no result. An output register holds the last result, so
// a new word is taken while it waits; a stalled output holds the
// update cycle. Set rows are marked fresh by flip-flops at reset, so the block
// is ready right after reset. Registers: set_bits at 0x0, ways_in_use at 0x4,
// block_bits at 0x8; write them only while the block is idle.
module set_associative_lru_cache_sim (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire logic                          psel,
    input  wire logic                          penable,
    input  wire logic                          pwrite,
    input  wire logic [salc_pkg::PADDR_W-1:0]  paddr,
    input  wire logic [salc_pkg::PDATA_W-1:0]  pwdata,
    output logic      [salc_pkg::PDATA_W-1:0]  prdata,
    output logic                               pready,
    input  wire logic                          in_valid,
    output logic                               in_stall,
    input  salc_pkg::in_word_t                 in_word,
    output logic                               out_valid,
    input  wire logic                          out_stall,
    output salc_pkg::out_word_t                out_word
);
    import salc_pkg::*;

    cfg_t                  cfg;
    state_t                state_reg, state_next;
    logic [SET_IDX_W-1:0]  set_reg;
    logic [TAG_W-1:0]      tag_reg;
    logic                  first_of_two_reg;
    logic [MAX_SETS-1:0]   row_init_reg;
    logic [CNT_W-1:0]      hit_reg, hit_next;
    logic [CNT_W-1:0]      miss_reg, miss_next;
    logic [CNT_W-1:0]      evict_reg, evict_next;
    logic                  out_valid_reg;
    out_word_t             out_word_reg;

    logic [ADDR_WIDTH-1:0] blk;
    logic [SET_IDX_W-1:0]  set_calc;
    logic [TAG_W-1:0]      tag_calc;
    logic                  in_fire;
    logic                  in_access;
    logic                  out_free;
    logic                  update;
    logic                  ram_re;
    logic [SET_IDX_W-1:0]  ram_addr;
    logic [ROW_W-1:0]      ram_rdata;
    row_t                  cur_row;
    row_t                  new_row;
    logic [1:0]            outcome;

    salc_cfg u_cfg (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    // Split the address into set index and tag.
    assign blk      = in_word.address >> cfg.block_bits;
    assign set_calc = blk[SET_IDX_W-1:0] & ~({SET_IDX_W{1'b1}} << cfg.set_bits);
    assign tag_calc = blk >> cfg.set_bits;

    assign in_fire   = in_valid && !in_stall;
    assign in_access = in_fire && (in_word.cmd != CMD_IFETCH);
    assign out_free  = !out_valid_reg || !out_stall;

    // Set memory: one row per set holds every way.
    salc_set_ram #(
        .WIDTH (ROW_W),
        .DEPTH (MAX_SETS)
    ) u_ram (
        .clk   (clk),
        .we    (update),
        .re    (ram_re),
        .addr  (ram_addr),
        .wdata (new_row),
        .rdata (ram_rdata)
    );

    // A row never written since reset reads as all lines empty.
    assign cur_row = row_init_reg[set_reg] ? row_t'(ram_rdata) : '0;

    salc_lookup u_lookup (
        .row     (cur_row),
        .tag     (tag_reg),
        .ways    (cfg.ways),
        .new_row (new_row),
        .outcome (outcome)
    );

    // Next state.
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (in_access)
                begin
                    state_next = ST_LOOKUP;
                end
            end
            ST_LOOKUP:
            begin
                if (out_free)
                begin
                    state_next = first_of_two_reg ? ST_REREAD : ST_IDLE;
                end
            end
            ST_REREAD:
            begin
                state_next = ST_LOOKUP;
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // State outputs: input stall, memory read and write-back.
    always_comb
    begin
        in_stall = 1'b1;
        ram_re   = 1'b0;
        ram_addr = set_reg;
        update   = 1'b0;
        case (state_reg)
            ST_IDLE:
            begin
                in_stall = 1'b0;
                ram_re   = in_valid && (in_word.cmd != CMD_IFETCH);
                ram_addr = set_calc;
            end
            ST_LOOKUP:
            begin
                update = out_free;
            end
            ST_REREAD:
            begin
                ram_re = 1'b1;
            end
            default:
            begin
                in_stall = 1'b1;
            end
        endcase
    end

    // Running totals after this access.
    always_comb
    begin
        hit_next   = hit_reg;
        miss_next  = miss_reg;
        evict_next = evict_reg;
        if (outcome == OUT_HIT)
        begin
            hit_next = sat_inc(hit_reg);
        end
        else
        begin
            miss_next = sat_inc(miss_reg);
        end
        if (outcome == OUT_EVICT)
        begin
            evict_next = sat_inc(evict_reg);
        end
    end

    // Control registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            row_init_reg  <= '0;
            hit_reg       <= '0;
            miss_reg      <= '0;
            evict_reg     <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            if (update)
            begin
                row_init_reg[set_reg] <= 1'b1;
                hit_reg               <= hit_next;
                miss_reg              <= miss_next;
                evict_reg             <= evict_next;
                out_valid_reg         <= 1'b1;
            end
            else if (!out_stall)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // Access and result payload.
    always_ff @(posedge clk)
    begin
        if (in_access)
        begin
            set_reg          <= set_calc;
            tag_reg          <= tag_calc;
            first_of_two_reg <= (in_word.cmd == CMD_MODIFY);
        end
        else if (update)
        begin
            first_of_two_reg <= 1'b0;
        end
        if (update)
        begin
            out_word_reg.outcome        <= outcome;
            out_word_reg.last_of_item   <= !first_of_two_reg;
            out_word_reg.hit_total      <= hit_next;
            out_word_reg.miss_total     <= miss_next;
            out_word_reg.eviction_total <= evict_next;
        end
    end

    assign out_valid = out_valid_reg;
    assign out_word  = out_word_reg;

endmodule

`default_nettype wire

// ===== design/salc_checker.sv =====
`default_nettype none

// Port-level checks on the cache tag store.
module salc_checker (
    input wire logic          clk,
    input wire logic          rst_n,
    input wire logic          in_valid,
    input wire logic          in_stall,
    input salc_pkg::in_word_t in_word,
    input wire logic          out_valid,
    input wire logic          out_stall,
    input salc_pkg::out_word_t out_word
);
    import salc_pkg::*;

    // A stalled result word holds.
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid && $stable(out_word))
        else $error("stalled result word changed");

    // An accepted access keeps the input stalled while the set is looked up.
    a_busy: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && !in_stall && (in_word.cmd != CMD_IFETCH) |=> in_stall)
        else $error("input taken while an access was in flight");

    // A hit implies a nonzero hit total, an eviction a nonzero eviction total.
    a_totals: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> ((out_word.outcome != OUT_HIT) || (out_word.hit_total != '0)) &&
                      ((out_word.outcome != OUT_EVICT) || (out_word.eviction_total != '0)))
        else $error("total does not reflect the outcome");

    // Evictions never outnumber misses.
    a_evict_le_miss: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> out_word.eviction_total <= out_word.miss_total)
        else $error("eviction total above miss total");

    // Hit and miss totals never decrease from one delivered word to the next.
    a_monotone: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && !out_stall) ##1 out_valid |->
            (out_word.hit_total >= $past(out_word.hit_total)) &&
            (out_word.miss_total >= $past(out_word.miss_total)))
        else $error("running total decreased");

endmodule

bind set_associative_lru_cache_sim salc_checker u_salc_checker (.*);

`default_nettype wire

// ===== bench/tb.sv =====
`timescale 1ns / 1ps

module tb;

    import salc_pkg::*;

    localparam int LINES             = MAX_SETS * MAX_WAYS;
    localparam int SEGMENTS          = 9;
    localparam int ITEMS_PER_SEGMENT = 205;
    localparam int SETTLE_CYCLES     = 8;
    localparam int DRAIN_CYCLES      = 20;
    localparam int WATCHDOG_LIMIT    = 4000;
    localparam int MAX_POOL          = 12;
    localparam int DIRECTED_ROWS     = 23;

    typedef enum logic {
        ROW_ITEM,
        ROW_REG
    } row_kind_t;

    // One row of the directed table: either a trace word or a register write.
    typedef struct packed {
        row_kind_t             kind;
        cmd_t                  cmd;
        logic [1:0]            reg_idx;
        logic [ADDR_WIDTH-1:0] value;
        logic                  typed;
        outcome_t              outcome;
    } stim_row_t;

    logic                 clk;
    logic                 rst_n;
    logic                 psel;
    logic                 penable;
    logic                 pwrite;
    logic [PADDR_W-1:0]   paddr;
    logic [PDATA_W-1:0]   pwdata;
    logic [PDATA_W-1:0]   prdata;
    logic                 pready;
    logic                 in_valid;
    logic                 in_stall;
    in_word_t             in_word;
    logic                 out_valid;
    logic                 out_stall;
    out_word_t            out_word;

    // Shadow copy of the tag store, its registers and its totals.
    bit                   cached_valid [LINES];
    logic [ADDR_WIDTH-1:0] cached_tag  [LINES];
    logic [RANK_W-1:0]    cached_rank  [LINES];
    logic [CNT_W-1:0]     hit_count;
    logic [CNT_W-1:0]     miss_count;
    logic [CNT_W-1:0]     evict_count;
    logic [SET_BITS_W-1:0]   cfg_set_bits;
    logic [WAYS_W-1:0]       cfg_ways;
    logic [BLOCK_BITS_W-1:0] cfg_block_bits;

    out_word_t            outcome_fifo [$];
    logic [ADDR_WIDTH-1:0] tag_pool [MAX_POOL];
    int                   send_idle_pct;
    int                   recv_idle_pct;
    int                   mismatch_count;
    int                   idle_cycles;

    // Directed trace: reset configuration first, then the clamped extremes.
    stim_row_t directed_rows [DIRECTED_ROWS] = '{
        '{ROW_ITEM, CMD_LOAD,   REG_SET_BITS,   48'h0,            1'b1, OUT_MISS},
        '{ROW_ITEM, CMD_LOAD,   REG_SET_BITS,   48'hF,            1'b1, OUT_HIT},
        '{ROW_ITEM, CMD_STORE,  REG_SET_BITS,   48'hFFFF_FFFF_FFFF, 1'b1, OUT_MISS},
        '{ROW_ITEM, CMD_MODIFY, REG_SET_BITS,   48'h10,           1'b0, OUT_HIT},
        '{ROW_ITEM, CMD_IFETCH, REG_SET_BITS,   48'hAAAA_AAAA_AAAA, 1'b0, OUT_HIT},
        '{ROW_ITEM, CMD_LOAD,   REG_SET_BITS,   48'h100,          1'b1, OUT_EVICT},
        '{ROW_ITEM, CMD_STORE,  REG_SET_BITS,   48'h0,            1'b1, OUT_EVICT},
        '{ROW_ITEM, CMD_IFETCH, REG_SET_BITS,   48'h5555_5555_5555, 1'b0, OUT_HIT},
        '{ROW_REG,  CMD_LOAD,   REG_SET_BITS,   48'd7,            1'b0, OUT_HIT},
        '{ROW_REG,  CMD_LOAD,   REG_WAYS,       48'd0,            1'b0, OUT_HIT},
        '{ROW_REG,  CMD_LOAD,   REG_BLOCK_BITS, 48'd31,           1'b0, OUT_HIT},
        '{ROW_ITEM, CMD_LOAD,   REG_SET_BITS,   48'hFFFF_FFFF_FFFF, 1'b0, OUT_HIT},
        '{ROW_ITEM, CMD_MODIFY, REG_SET_BITS,   48'h0,            1'b0, OUT_HIT},
        '{ROW_REG,  CMD_LOAD,   REG_WAYS,       48'd15,           1'b0, OUT_HIT},
        '{ROW_REG,  CMD_LOAD,   REG_BLOCK_BITS, 48'd0,            1'b0, OUT_HIT},
        '{ROW_REG,  CMD_LOAD,   REG_SET_BITS,   48'd0,            1'b0, OUT_HIT},
        '{ROW_ITEM, CMD_STORE,  REG_SET_BITS,   48'h1,            1'b0, OUT_HIT},
        '{ROW_ITEM, CMD_LOAD,   REG_SET_BITS,   48'h2,            1'b0, OUT_HIT},
        '{ROW_ITEM, CMD_LOAD,   REG_SET_BITS,   48'h1,            1'b0, OUT_HIT},
        '{ROW_ITEM, CMD_MODIFY, REG_SET_BITS,   48'h3,            1'b0, OUT_HIT},
        '{ROW_ITEM, CMD_LOAD,   REG_SET_BITS,   48'h8000_0000_0000, 1'b0, OUT_HIT},
        '{ROW_REG,  CMD_LOAD,   REG_WAYS,       48'd8,            1'b0, OUT_HIT},
        '{ROW_ITEM, CMD_LOAD,   REG_SET_BITS,   48'h2,            1'b0, OUT_HIT}
    };

    set_associative_lru_cache_sim u_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .psel      (psel),
        .penable   (penable),
        .pwrite    (pwrite),
        .paddr     (paddr),
        .pwdata    (pwdata),
        .prdata    (prdata),
        .pready    (pready),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .in_word   (in_word),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .out_word  (out_word)
    );

    initial
    begin
        clk = 1'b0;
        forever #2 clk = ~clk;
    end

    // Set index bits in effect: clamped so the set count fits the store.
    function automatic int unsigned active_set_bits();
        int unsigned s;
        s = cfg_set_bits;
        while (s > 0 && (1 << s) > MAX_SETS)
            s--;
        return s;
    endfunction

    // Ways in effect: zero acts as one, anything too large as the maximum.
    function automatic int unsigned active_ways();
        int unsigned w;
        w = cfg_ways;
        if (w == 0)
            w = 1;
        if (w > MAX_WAYS)
            w = MAX_WAYS;
        return w;
    endfunction

    // The touched way becomes most recent; younger valid ways age by one.
    task automatic promote_way(input int unsigned base, input int unsigned ways,
                               input int unsigned w, input int unsigned old_rank);
        for (int unsigned i = 0; i < ways; i++)
        begin
            if (i != w && cached_valid[base + i] && cached_rank[base + i] < old_rank
                && cached_rank[base + i] < MAX_WAYS - 1)
                cached_rank[base + i] = cached_rank[base + i] + 1'b1;
        end
        cached_rank[base + w] = '0;
    endtask

    // One cache access: look up the set, update ranks and totals, build the word.
    task automatic cache_access(input logic [ADDR_WIDTH-1:0] addr, input bit last,
                                output out_word_t r);
        int unsigned           s;
        int unsigned           ways;
        int unsigned           set_idx;
        int unsigned           base;
        int unsigned           victim;
        logic [ADDR_WIDTH-1:0] blk;
        logic [ADDR_WIDTH-1:0] tag;
        bit                    found;
        outcome_t              oc;
        s       = active_set_bits();
        ways    = active_ways();
        blk     = addr >> cfg_block_bits;
        set_idx = 32'((blk & ((48'd1 << s) - 48'd1)) % MAX_SETS);
        tag     = blk >> s;
        base    = set_idx * MAX_WAYS;
        found   = 1'b0;
        oc      = OUT_HIT;
        for (int unsigned i = 0; i < ways; i++)
        begin
            if (!found && cached_valid[base + i] && cached_tag[base + i] == tag)
            begin
                promote_way(base, ways, i, cached_rank[base + i]);
                if (hit_count != '1)
                    hit_count++;
                found = 1'b1;
            end
        end
        if (!found)
        begin
            if (miss_count != '1)
                miss_count++;
            victim = ways;
            for (int unsigned i = 0; i < ways; i++)
            begin
                if (victim == ways && !cached_valid[base + i])
                    victim = i;
            end
            if (victim < ways)
            begin
                // Filling an empty way: it counts as older than every other way.
                oc = OUT_MISS;
                cached_valid[base + victim] = 1'b1;
                promote_way(base, ways, victim, MAX_WAYS);
            end
            else
            begin
                // All ways full: evict the oldest, lowest way on a tie.
                victim = 0;
                for (int unsigned i = 1; i < ways; i++)
                begin
                    if (cached_rank[base + i] > cached_rank[base + victim])
                        victim = i;
                end
                oc = OUT_EVICT;
                if (evict_count != '1)
                    evict_count++;
                promote_way(base, ways, victim, cached_rank[base + victim]);
            end
            cached_tag[base + victim] = tag;
        end
        r.outcome        = oc;
        r.last_of_item   = last;
        r.hit_total      = hit_count;
        r.miss_total     = miss_count;
        r.eviction_total = evict_count;
    endtask

    // Expected words for one accepted trace word; a typed outcome overrides.
    task automatic predict_trace_word(input in_word_t w, input bit typed,
                                      input outcome_t forced);
        out_word_t r;
        if (w.cmd == CMD_IFETCH)
            return;
        if (w.cmd == CMD_MODIFY)
        begin
            cache_access(w.address, 1'b0, r);
            outcome_fifo.push_back(r);
        end
        cache_access(w.address, 1'b1, r);
        if (typed)
            r.outcome = forced;
        outcome_fifo.push_back(r);
    endtask

    // Address from the current tag pool, aimed at the first few sets.
    function automatic logic [ADDR_WIDTH-1:0] pool_address(input int unsigned pool_size);
        int unsigned s;
        int unsigned set_span;
        logic [63:0] blk;
        logic [63:0] offset;
        logic [63:0] full;
        s        = active_set_bits();
        set_span = ((1 << s) < 4) ? (1 << s) : 4;
        blk      = ({16'd0, tag_pool[$urandom_range(0, pool_size - 1)]} << s)
                   | 64'($urandom_range(0, set_span - 1));
        offset   = {$urandom, $urandom} & ((64'd1 << cfg_block_bits) - 64'd1);
        full     = (blk << cfg_block_bits) | offset;
        return full[ADDR_WIDTH-1:0];
    endfunction

    task automatic report_mismatch(input string msg);
        $display("[%0t] mismatch: %s", $realtime, msg);
        mismatch_count++;
    endtask

    // Offer one word after a random gap and wait until it is taken.
    task automatic send_word(input in_word_t w, input bit typed, input outcome_t forced);
        if ($urandom_range(0, 99) < send_idle_pct)
        begin
            in_valid <= 1'b0;
            do
                @(posedge clk);
            while ($urandom_range(0, 99) < send_idle_pct);
        end
        in_valid <= 1'b1;
        in_word  <= w;
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
        predict_trace_word(w, typed, forced);
    endtask

    // Stop sending, let every expected word arrive, then let the block go quiet.
    task automatic settle_block();
        in_valid <= 1'b0;
        while (outcome_fifo.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    // Register write: setup cycle, then access cycle until pready.
    task automatic write_reg(input logic [1:0] idx, input logic [PDATA_W-1:0] val);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= val;
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        while (!pready)
            @(posedge clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        case (idx)
            REG_SET_BITS:   cfg_set_bits   = val[SET_BITS_W-1:0];
            REG_WAYS:       cfg_ways       = val[WAYS_W-1:0];
            REG_BLOCK_BITS: cfg_block_bits = val[BLOCK_BITS_W-1:0];
            default:        ;
        endcase
        @(posedge clk);
    endtask

    // Receiver stall, drawn fresh every cycle.
    always @(posedge clk)
    begin
        out_stall <= ($urandom_range(0, 99) < recv_idle_pct);
    end

    // Compare each taken result word with the oldest expected one.
    always @(posedge clk)
    begin : check_results
        out_word_t want;
        if (rst_n && out_valid && !out_stall)
        begin
            if (outcome_fifo.size() == 0)
                report_mismatch($sformatf("result word %h with nothing expected", out_word));
            else
            begin
                want = outcome_fifo.pop_front();
                if (out_word.outcome !== want.outcome)
                    report_mismatch($sformatf("outcome %0d, expected %0d",
                                              out_word.outcome, want.outcome));
                if (out_word.last_of_item !== want.last_of_item)
                    report_mismatch($sformatf("last_of_item %0b, expected %0b",
                                              out_word.last_of_item, want.last_of_item));
                if (out_word.hit_total !== want.hit_total)
                    report_mismatch($sformatf("hit_total %0d, expected %0d",
                                              out_word.hit_total, want.hit_total));
                if (out_word.miss_total !== want.miss_total)
                    report_mismatch($sformatf("miss_total %0d, expected %0d",
                                              out_word.miss_total, want.miss_total));
                if (out_word.eviction_total !== want.eviction_total)
                    report_mismatch($sformatf("eviction_total %0d, expected %0d",
                                              out_word.eviction_total, want.eviction_total));
            end
        end
    end

    // Watchdog: end the run when nothing moves on any port for too long.
    always @(posedge clk)
    begin
        if ((in_valid && !in_stall) || (out_valid && !out_stall) || (psel && penable))
            idle_cycles <= 0;
        else if (idle_cycles >= WATCHDOG_LIMIT)
        begin
            $display("DONE: errors detected");
            $finish;
        end
        else
            idle_cycles <= idle_cycles + 1;
    end

    initial
    begin
        in_word_t    w;
        int unsigned pool_size;
        int unsigned sent;
        int unsigned pick;
        bit          paused;

        // Known values on every input, with reset held low.
        rst_n     <= 1'b0;
        psel      <= 1'b0;
        penable   <= 1'b0;
        pwrite    <= 1'b0;
        paddr     <= '0;
        pwdata    <= '0;
        in_valid  <= 1'b0;
        in_word   <= '0;
        out_stall <= 1'b0;
        idle_cycles    = 0;
        mismatch_count = 0;
        send_idle_pct  = 26;
        recv_idle_pct  = 63;

        // Shadow state after reset.
        for (int i = 0; i < LINES; i++)
        begin
            cached_valid[i] = 1'b0;
            cached_tag[i]   = '0;
            cached_rank[i]  = '0;
        end
        hit_count      = '0;
        miss_count     = '0;
        evict_count    = '0;
        cfg_set_bits   = RST_SET_BITS;
        cfg_ways       = RST_WAYS;
        cfg_block_bits = RST_BLOCK_BITS;

        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed table.
        for (int r = 0; r < DIRECTED_ROWS; r++)
        begin
            if (directed_rows[r].kind == ROW_REG)
            begin
                settle_block();
                write_reg(directed_rows[r].reg_idx, PDATA_W'(directed_rows[r].value));
            end
            else
            begin
                w.cmd     = directed_rows[r].cmd;
                w.address = directed_rows[r].value;
                send_word(w, directed_rows[r].typed, directed_rows[r].outcome);
            end
        end

        // Random segments, each under a fresh configuration and tag pool.
        for (int seg = 0; seg < SEGMENTS; seg++)
        begin
            settle_block();
            write_reg(REG_SET_BITS, PDATA_W'($urandom_range(0, 7)));
            write_reg(REG_WAYS, PDATA_W'($urandom_range(0, 15)));
            write_reg(REG_BLOCK_BITS, PDATA_W'($urandom_range(0, 31)));
            pool_size = $urandom_range(2, MAX_POOL);
            for (int k = 0; k < MAX_POOL; k++)
                tag_pool[k] = ADDR_WIDTH'({$urandom, $urandom});
            send_idle_pct = (seg < 3) ? 26 : (seg < 6) ? 63 : 0;
            recv_idle_pct = (seg < 3) ? 63 : (seg < 6) ? 26 : 0;
            sent   = 0;
            paused = 1'b0;
            while (sent < ITEMS_PER_SEGMENT)
            begin
                // Halfway through one segment, hold off until the pipe is empty.
                if (seg == 4 && !paused && sent == ITEMS_PER_SEGMENT / 2)
                begin
                    settle_block();
                    paused = 1'b1;
                end
                pick = $urandom_range(0, 9);
                if (pick == 0)
                    w.cmd = CMD_IFETCH;
                else if (pick < 4)
                    w.cmd = CMD_MODIFY;
                else
                    w.cmd = (pick < 7) ? CMD_LOAD : CMD_STORE;
                if ($urandom_range(0, 9) == 0)
                    w.address = ADDR_WIDTH'({$urandom, $urandom});
                else
                    w.address = pool_address(pool_size);
                send_word(w, 1'b0, OUT_HIT);
                sent++;
            end
        end

        // Drain, then watch a while longer for stray words.
        in_valid <= 1'b0;
        while (outcome_fifo.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);

        if (mismatch_count == 0)
            $display("DONE: 0 errors");
        else
            $display("DONE: errors detected");
        $finish;
    end

endmodule
